// ----- hw/rtl/daps_pkg.sv -----
// ----------------------------------------------------------------------------
// Display and audio power sequencer package
// Shared widths, operation codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
package daps_pkg;

  localparam int TimerBits = 16;
  localparam int PwmMax = 1000;
  localparam int DisplayStepDelayMs = 10;
  localparam int PwmOffDelayMs = 10;
  localparam int AudioStepDelayMs = 10;
  localparam int BridgePulseTicks = 10;

  localparam int CfgIdxBits = 3;

  typedef logic [TimerBits-1:0] timer_t;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_REQUEST   = 3'd1,
    OP_BRIGHT    = 3'd2,
    OP_BRIDGE    = 3'd3,
    OP_FORCE_OFF = 3'd4,
    OP_SAFE      = 3'd5,
    OP_STARTUP   = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SCALER_GOOD   = 3'd0,
    CFG_LCD_GOOD      = 3'd1,
    CFG_BL_GOOD       = 3'd2,
    CFG_VERIFY_TO     = 3'd3,
    CFG_PGOOD_TO      = 3'd4,
    CFG_SUSPEND_LOW   = 3'd5,
    CFG_BUTTON_PULSE  = 3'd6,
    CFG_COOLDOWN      = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    DS_IDLE, DS_U_SCALER, DS_U_WSCALER, DS_U_VSCALER, DS_U_RST, DS_U_WRST,
    DS_U_LCD, DS_U_WLCD, DS_U_VLCD, DS_U_BL, DS_U_VBL, DS_U_DONE,
    DS_D_PWM, DS_D_WPWM, DS_D_BL, DS_D_WBL, DS_D_LCD, DS_D_WLCD,
    DS_D_RST, DS_D_SCALER, DS_D_DONE,
    DS_B_PWM, DS_B_WAIT, DS_B_GPIO, DS_B_DONE
  } disp_step_e;

  typedef enum logic [3:0] {
    AS_IDLE, AS_ON_PWR, AS_ON_WSDZ, AS_ON_SDZ, AS_ON_WMUTE, AS_ON_DONE,
    AS_OFF_MUTE, AS_OFF_WAIT, AS_OFF_SDZ, AS_OFF_PWR, AS_OFF_DONE
  } aud_step_e;

  localparam logic [6:0] BitScaler = 7'h01;
  localparam logic [6:0] BitLcd    = 7'h02;
  localparam logic [6:0] BitBl     = 7'h04;
  localparam logic [6:0] BitAudio  = 7'h08;
  localparam logic [6:0] BitTouch  = 7'h40;
  localparam logic [6:0] BitSimple = 7'h70;
  localparam logic [6:0] BitDisp   = 7'h07;

  localparam timer_t TimerMax = {TimerBits{1'b1}};

  function automatic timer_t timer_inc(timer_t t);
    timer_inc = (t == TimerMax) ? t : t + timer_t'(1);
  endfunction

  // A 16-bit delay above the saturation value is never reached.
  function automatic logic timer_ge(timer_t t, logic [15:0] d);
    timer_ge = ({16'd0, t} >= {{TimerBits{1'b0}}, d});
  endfunction

endpackage

// ----- hw/rtl/display_audio_power_sequencer.sv -----
// ----------------------------------------------------------------------------
// Display and audio power sequencer
// Seven-rail power-domain sequencer driven by one event word at a time.
// ----------------------------------------------------------------------------
// Each accepted event word is processed in one pass: the whole state update
// is a single combinational pass from the state registers into a result
// register, so a new word can be accepted in every cycle unless a stalled
// result holds the input, and the result for a word appears in the cycle
// after it is accepted. Events are 1 ms ticks, domain requests, brightness
// sets, bridge reset pulses, forced off, safe state and startup begin. Every
// word yields exactly one result word. The user must write configuration
// registers through the cfg port while the block is idle (not enforced).
module display_audio_power_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [6:0]  domain_sel_i,
  input  logic [6:0]  domain_value_i,
  input  logic        bad_bits_i,
  input  logic [9:0]  brightness_i,
  input  logic        power_good_i,
  input  logic        suspend_level_i,
  input  logic [13:0] scaler_rail_mv_i,
  input  logic [13:0] lcd_rail_mv_i,
  input  logic [13:0] backlight_rail_mv_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        request_rejected_o,
  output logic [6:0]  domain_state_o,
  output logic [9:0]  pwm_compare_o,
  output logic        pwm_running_o,
  output logic        bridge_reset_n_o,
  output logic        amp_shutdown_n_o,
  output logic        amp_mute_o,
  output logic        power_button_n_o,
  output logic        pgood_fault_o,
  output logic        seq_abort_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [daps_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import daps_pkg::*;

  logic [13:0] scaler_good_q, lcd_good_q, bl_good_q;
  logic [15:0] verify_to_q, pgood_to_q, sus_low_q, btn_pulse_q, cooldown_q;

  logic [6:0]  dom_q, dom_d;
  logic [9:0]  bright_q, bright_d, pwm_q, pwm_d;
  disp_step_e  ds_q, ds_d;
  aud_step_e   as_q, as_d;
  timer_t      dt_q, dt_d, at_q, at_d, bt_q, bt_d, st_q, st_d;
  timer_t      sut_q, sut_d, but_q, but_d, ct_q, ct_d;
  logic        upbl_q, upbl_d, ampa_q, ampa_d, brp_q, brp_d, sw_q, sw_d;
  logic        strk_q, strk_d, btnp_q, btnp_d, cda_q, cda_d;
  logic        p_rst_q, p_rst_d, p_sdz_q, p_sdz_d, p_mute_q, p_mute_d;
  logic        p_btn_q, p_btn_d, p_pwm_q, p_pwm_d;
  logic        rej_d, fpg_d, fab_d;
  logic        ovalid_q, rej_q, fpg_q, fab_q;

  logic        accept;
  assign in_stall_o  = ovalid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scaler_good_q <= '0;
      lcd_good_q    <= '0;
      bl_good_q     <= 14'd9000;
      verify_to_q   <= '0;
      pgood_to_q    <= '0;
      sus_low_q     <= '0;
      btn_pulse_q   <= '0;
      cooldown_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SCALER_GOOD:  scaler_good_q <= cfg_data_i[13:0];
        CFG_LCD_GOOD:     lcd_good_q    <= cfg_data_i[13:0];
        CFG_BL_GOOD:      bl_good_q     <= cfg_data_i[13:0];
        CFG_VERIFY_TO:    verify_to_q   <= cfg_data_i;
        CFG_PGOOD_TO:     pgood_to_q    <= cfg_data_i;
        CFG_SUSPEND_LOW:  sus_low_q     <= cfg_data_i;
        CFG_BUTTON_PULSE: btn_pulse_q   <= cfg_data_i;
        CFG_COOLDOWN:     cooldown_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [6:0] m, v, st, fut;
  logic on_s, on_l, on_b, off_s, off_l, off_b, apply, nbl;
  disp_step_e nxt;
  logic [9:0] bclamp;

  always_comb begin
    dom_d = dom_q; bright_d = bright_q; pwm_d = pwm_q; ds_d = ds_q; as_d = as_q;
    dt_d = dt_q; at_d = at_q; bt_d = bt_q; st_d = st_q; sut_d = sut_q;
    but_d = but_q; ct_d = ct_q; upbl_d = upbl_q; ampa_d = ampa_q; brp_d = brp_q;
    sw_d = sw_q; strk_d = strk_q; btnp_d = btnp_q; cda_d = cda_q;
    p_rst_d = p_rst_q; p_sdz_d = p_sdz_q; p_mute_d = p_mute_q;
    p_btn_d = p_btn_q; p_pwm_d = p_pwm_q;
    rej_d = 1'b0; fpg_d = 1'b0; fab_d = 1'b0;
    m = domain_sel_i; v = domain_value_i; st = dom_q;
    fut = (st & ~m) | (v & m);
    on_s = m[0] & v[0]; on_l = m[1] & v[1]; on_b = m[2] & v[2];
    off_s = m[0] & ~v[0]; off_l = m[1] & ~v[1]; off_b = m[2] & ~v[2];
    apply = 1'b0; nbl = upbl_q; nxt = DS_IDLE;
    bclamp = (brightness_i > 10'(PwmMax)) ? 10'(PwmMax) : brightness_i;

    case (op_e'(operation_i))
      OP_TICK: begin
        dt_d = timer_inc(dt_q); at_d = timer_inc(at_q); bt_d = timer_inc(bt_q);
        st_d = timer_inc(st_q); sut_d = timer_inc(sut_q);
        but_d = timer_inc(but_q); ct_d = timer_inc(ct_q);
        if (sw_q) begin
          if (power_good_i) begin
            sw_d = 1'b0; upbl_d = 1'b0; ds_d = DS_U_SCALER;
            dom_d = dom_d | BitTouch | BitAudio;
          end else if (timer_ge(st_d, pgood_to_q)) begin
            sw_d = 1'b0; fpg_d = 1'b1;
          end
        end
        if (ds_d != DS_IDLE && ds_d < DS_D_PWM && !power_good_i) begin
          fpg_d = 1'b1; fab_d = 1'b1;
        end else begin
          case (ds_d)
            DS_U_SCALER: begin
              dom_d = dom_d | BitScaler; dt_d = '0; ds_d = DS_U_WSCALER;
            end
            DS_U_WSCALER: if (timer_ge(dt_d, 16'(DisplayStepDelayMs))) begin
              dt_d = '0; ds_d = DS_U_VSCALER;
            end
            DS_U_VSCALER: begin
              if (scaler_rail_mv_i >= scaler_good_q) ds_d = DS_U_RST;
              else if (timer_ge(dt_d, verify_to_q)) fab_d = 1'b1;
            end
            DS_U_RST: begin
              p_rst_d = 1'b1; dt_d = '0; ds_d = DS_U_WRST;
            end
            DS_U_WRST: if (timer_ge(dt_d, 16'(DisplayStepDelayMs))) ds_d = DS_U_LCD;
            DS_U_LCD: begin
              dom_d = dom_d | BitLcd; dt_d = '0; ds_d = DS_U_WLCD;
            end
            DS_U_WLCD: if (timer_ge(dt_d, 16'(DisplayStepDelayMs))) begin
              dt_d = '0; ds_d = DS_U_VLCD;
            end
            DS_U_VLCD: begin
              if (lcd_rail_mv_i >= lcd_good_q) ds_d = upbl_d ? DS_U_BL : DS_U_DONE;
              else if (timer_ge(dt_d, verify_to_q)) fab_d = 1'b1;
            end
            DS_U_BL: begin
              dom_d = dom_d | BitBl; p_pwm_d = 1'b1; pwm_d = bright_q;
              dt_d = '0; ds_d = DS_U_VBL;
            end
            DS_U_VBL: begin
              if (backlight_rail_mv_i >= bl_good_q) ds_d = DS_U_DONE;
              else if (timer_ge(dt_d, verify_to_q)) fab_d = 1'b1;
            end
            DS_D_PWM: begin
              pwm_d = '0; bright_d = '0; dt_d = '0; ds_d = DS_D_WPWM;
            end
            DS_B_PWM: begin
              pwm_d = '0; bright_d = '0; dt_d = '0; ds_d = DS_B_WAIT;
            end
            DS_D_WPWM: if (timer_ge(dt_d, 16'(PwmOffDelayMs))) ds_d = DS_D_BL;
            DS_D_BL: begin
              dom_d = dom_d & ~BitBl; dt_d = '0; ds_d = DS_D_WBL;
            end
            DS_D_WBL: if (timer_ge(dt_d, 16'(DisplayStepDelayMs))) ds_d = DS_D_LCD;
            DS_D_LCD: begin
              dom_d = dom_d & ~BitLcd; dt_d = '0; ds_d = DS_D_WLCD;
            end
            DS_D_WLCD: if (timer_ge(dt_d, 16'(DisplayStepDelayMs))) ds_d = DS_D_RST;
            DS_D_RST: begin
              p_rst_d = 1'b0; ds_d = DS_D_SCALER;
            end
            DS_D_SCALER: begin
              dom_d = dom_d & ~BitScaler; ds_d = DS_D_DONE;
            end
            DS_B_WAIT: if (timer_ge(dt_d, 16'(PwmOffDelayMs))) ds_d = DS_B_GPIO;
            DS_B_GPIO: begin
              dom_d = dom_d & ~BitBl; ds_d = DS_B_DONE;
            end
            default: ds_d = DS_IDLE;
          endcase
        end
        case (as_q)
          AS_ON_PWR: begin
            dom_d = dom_d | BitAudio; at_d = '0; as_d = AS_ON_WSDZ;
          end
          AS_ON_WSDZ: if (timer_ge(at_d, 16'(AudioStepDelayMs))) as_d = AS_ON_SDZ;
          AS_ON_SDZ: begin
            p_sdz_d = 1'b1; at_d = '0; as_d = AS_ON_WMUTE;
          end
          AS_ON_WMUTE: if (timer_ge(at_d, 16'(AudioStepDelayMs))) as_d = AS_ON_DONE;
          AS_ON_DONE: begin
            p_mute_d = 1'b0; ampa_d = 1'b1; as_d = AS_IDLE;
          end
          AS_OFF_MUTE: begin
            p_mute_d = 1'b1; at_d = '0; as_d = AS_OFF_WAIT;
          end
          AS_OFF_WAIT: if (timer_ge(at_d, 16'(AudioStepDelayMs))) as_d = AS_OFF_SDZ;
          AS_OFF_SDZ: begin
            p_sdz_d = 1'b0; as_d = AS_OFF_PWR;
          end
          AS_OFF_PWR: begin
            dom_d = dom_d & ~BitAudio; ampa_d = 1'b0; as_d = AS_OFF_DONE;
          end
          default: as_d = AS_IDLE;
        endcase
        if (brp_q && timer_ge(bt_d, 16'(BridgePulseTicks))) begin
          p_rst_d = 1'b1; brp_d = 1'b0;
        end
        if (btnp_q) begin
          if (timer_ge(but_d, btn_pulse_q)) begin
            p_btn_d = 1'b1; btnp_d = 1'b0; cda_d = 1'b1; ct_d = '0;
          end
        end else if (!power_good_i) begin
          strk_d = 1'b0;
        end else if (!(cda_q && !timer_ge(ct_d, cooldown_q))) begin
          if (!suspend_level_i) begin
            if (!strk_q) begin
              strk_d = 1'b1; sut_d = '0;
            end else if (timer_ge(sut_d, sus_low_q)) begin
              p_btn_d = 1'b0; btnp_d = 1'b1; but_d = '0; strk_d = 1'b0;
            end
          end else begin
            strk_d = 1'b0;
          end
        end
      end
      OP_REQUEST: begin
        if (bad_bits_i) rej_d = 1'b1;
        else if (on_b && (!fut[0] || !fut[1])) rej_d = 1'b1;
        else if (on_l && !fut[0]) rej_d = 1'b1;
        else if ((m & BitDisp) != '0) begin
          if (ds_q != DS_IDLE) rej_d = 1'b1;
          else if (off_s || off_l) begin
            nxt = DS_D_PWM; apply = 1'b1;
          end else if (off_b && st[2]) begin
            nxt = DS_B_PWM; apply = 1'b1;
          end else if (on_s && !st[0]) begin
            if (!power_good_i) rej_d = 1'b1;
            else begin
              nbl = on_b; nxt = DS_U_SCALER; apply = 1'b1;
            end
          end else if (on_l && st[0] && !st[1]) begin
            if (!power_good_i) rej_d = 1'b1;
            else begin
              nbl = on_b; nxt = DS_U_RST; apply = 1'b1;
            end
          end else if (on_b && st[0] && st[1] && !st[2]) begin
            if (!power_good_i) rej_d = 1'b1;
            else begin
              nxt = DS_U_BL; apply = 1'b1;
            end
          end
        end
        if (!rej_d) begin
          dom_d = (dom_q & ~(m & BitSimple)) | (v & m & BitSimple);
          if (m[3]) begin
            if (v[3]) begin
              if (as_q == AS_IDLE && !ampa_q) as_d = dom_d[3] ? AS_ON_SDZ : AS_ON_PWR;
            end else if (as_q != AS_IDLE || dom_d[3]) begin
              as_d = AS_OFF_MUTE;
            end
          end
          if (apply) begin
            upbl_d = nbl; ds_d = nxt;
          end
        end
      end
      OP_BRIGHT: begin
        bright_d = bclamp;
        if (dom_q[2] && (ds_q == DS_IDLE || (ds_q >= DS_U_SCALER && ds_q <= DS_U_DONE)))
          pwm_d = bclamp;
      end
      OP_BRIDGE: begin
        if (dom_q[0] && dom_q[1] && ds_q == DS_IDLE && !brp_q) begin
          p_rst_d = 1'b0; brp_d = 1'b1; bt_d = '0;
        end
      end
      OP_FORCE_OFF: begin
        if (m[3]) begin
          p_mute_d = 1'b1; p_sdz_d = 1'b0; dom_d = dom_d & ~BitAudio;
          as_d = AS_IDLE; ampa_d = 1'b0;
        end
        if ((m & BitDisp) != '0) begin
          pwm_d = '0; p_rst_d = 1'b0; dom_d = dom_d & ~BitDisp; bright_d = '0;
          ds_d = DS_IDLE; brp_d = 1'b0;
        end
        dom_d = dom_d & ~(m & BitSimple);
      end
      OP_SAFE: begin
        p_sdz_d = 1'b0; p_mute_d = 1'b1; p_btn_d = 1'b1; p_rst_d = 1'b0;
        pwm_d = '0; dom_d = '0; bright_d = '0; ds_d = DS_IDLE; as_d = AS_IDLE;
        sw_d = 1'b0; ampa_d = 1'b0;
      end
      OP_STARTUP: begin
        sw_d = 1'b1; st_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_q <= '0; bright_q <= '0; pwm_q <= '0; ds_q <= DS_IDLE; as_q <= AS_IDLE;
      dt_q <= '0; at_q <= '0; bt_q <= '0; st_q <= '0; sut_q <= '0;
      but_q <= '0; ct_q <= '0; upbl_q <= 1'b0; ampa_q <= 1'b0; brp_q <= 1'b0;
      sw_q <= 1'b0; strk_q <= 1'b0; btnp_q <= 1'b0; cda_q <= 1'b0;
      p_rst_q <= 1'b0; p_sdz_q <= 1'b0; p_mute_q <= 1'b1; p_btn_q <= 1'b1;
      p_pwm_q <= 1'b0; ovalid_q <= 1'b0; rej_q <= 1'b0; fpg_q <= 1'b0;
      fab_q <= 1'b0;
    end else begin
      if (accept) begin
        dom_q <= dom_d; bright_q <= bright_d; pwm_q <= pwm_d; ds_q <= ds_d;
        as_q <= as_d; dt_q <= dt_d; at_q <= at_d; bt_q <= bt_d; st_q <= st_d;
        sut_q <= sut_d; but_q <= but_d; ct_q <= ct_d; upbl_q <= upbl_d;
        ampa_q <= ampa_d; brp_q <= brp_d; sw_q <= sw_d; strk_q <= strk_d;
        btnp_q <= btnp_d; cda_q <= cda_d; p_rst_q <= p_rst_d; p_sdz_q <= p_sdz_d;
        p_mute_q <= p_mute_d; p_btn_q <= p_btn_d; p_pwm_q <= p_pwm_d;
        rej_q <= rej_d; fpg_q <= fpg_d; fab_q <= fab_d;
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = ovalid_q;
  assign request_rejected_o = rej_q;
  assign domain_state_o     = dom_q;
  assign pwm_compare_o      = pwm_q;
  assign pwm_running_o      = p_pwm_q;
  assign bridge_reset_n_o   = p_rst_q;
  assign amp_shutdown_n_o   = p_sdz_q;
  assign amp_mute_o         = p_mute_q;
  assign power_button_n_o   = p_btn_q;
  assign pgood_fault_o      = fpg_q;
  assign seq_abort_o        = fab_q;

  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pwm_q <= 10'(PwmMax)) else $error("pwm compare above limit");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q && $stable(dom_q))
    else $error("result changed while stalled");
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ovalid_q) else $error("input stalled with no result waiting");
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_stall_i && !in_valid_i |=> !ovalid_q)
    else $error("result word repeated");
endmodule
